@@ sv/tlr_pkg.sv @@
// Package of the teleinformation label reader: codes, widths, control word and microprogram.
package tlr_pkg;

  localparam int MAX_FIELD   = 16;
  localparam int LABEL_CHARS = 8;
  localparam int FIELD_W     = $clog2(MAX_FIELD + 1);
  localparam int FIELD_AW    = $clog2(MAX_FIELD);
  localparam int LABEL_AW    = (LABEL_CHARS > 1) ? $clog2(LABEL_CHARS) : 1;
  localparam int LABEL_W     = 64;
  localparam int LEN_W       = 4;
  localparam int TIMEOUT_W   = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_LABEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LABEL_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_ABORT = 2'd3;

  localparam logic [2:0] ST_FRAME = 3'd0;
  localparam logic [2:0] ST_LINE  = 3'd1;
  localparam logic [2:0] ST_LABEL = 3'd2;
  localparam logic [2:0] ST_VALUE = 3'd3;
  localparam logic [2:0] ST_CKSUM = 3'd4;
  localparam logic [2:0] ST_EOL   = 3'd5;

  localparam logic [1:0] RS_IDLE = 2'd0;
  localparam logic [1:0] RS_RUN  = 2'd1;
  localparam logic [1:0] RS_DATA = 2'd2;
  localparam logic [1:0] RS_ERR  = 2'd3;

  localparam logic [4:0] EV_NOP        = 5'd0;
  localparam logic [4:0] EV_FRAME_END  = 5'd1;
  localparam logic [4:0] EV_FRAME_GO   = 5'd2;
  localparam logic [4:0] EV_WAIT_START = 5'd3;
  localparam logic [4:0] EV_LINE_GO    = 5'd4;
  localparam logic [4:0] EV_LINE_ERR0  = 5'd5;
  localparam logic [4:0] EV_OVERFLOW   = 5'd6;
  localparam logic [4:0] EV_LABEL_DONE = 5'd7;
  localparam logic [4:0] EV_LABEL_CHAR = 5'd8;
  localparam logic [4:0] EV_VALUE_DONE = 5'd9;
  localparam logic [4:0] EV_VALUE_CHAR = 5'd10;
  localparam logic [4:0] EV_CKSUM_OK   = 5'd11;
  localparam logic [4:0] EV_CKSUM_BAD  = 5'd12;
  localparam logic [4:0] EV_FOUND      = 5'd13;
  localparam logic [4:0] EV_NOT_FOUND  = 5'd14;
  localparam logic [4:0] EV_LINE_ERR   = 5'd15;
  localparam logic [4:0] EV_TIMEOUT    = 5'd16;

  localparam logic [6:0] CH_STX   = 7'h02;
  localparam logic [6:0] CH_ETX   = 7'h03;
  localparam logic [6:0] CH_EOT   = 7'h04;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_SPACE = 7'h20;

  // Microprogram steps and jump conditions.
  localparam logic [1:0] UA_FETCH = 2'd0;
  localparam logic [1:0] UA_EXEC  = 2'd1;
  localparam logic [1:0] UA_DRAIN = 2'd2;

  localparam logic [1:0] UC_NEVER    = 2'd0;
  localparam logic [1:0] UC_ALWAYS   = 2'd1;
  localparam logic [1:0] UC_IN_ACC   = 2'd2;
  localparam logic [1:0] UC_OUT_LAST = 2'd3;

  typedef struct packed {
    logic       in_ready;
    logic       exec;
    logic       out_valid;
    logic [1:0] cond;
    logic [1:0] jump_to;
    logic [1:0] next_to;
  } tlr_uword_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic out_take;
  } tlr_ctrl_t;

  function automatic tlr_uword_t tlr_urom(input logic [1:0] addr);
    tlr_uword_t w;
    w = '0;
    unique case (addr)
      UA_FETCH: w = '{in_ready: 1'b1, exec: 1'b0, out_valid: 1'b0, cond: UC_IN_ACC,
                      jump_to: UA_EXEC, next_to: UA_FETCH};
      UA_EXEC:  w = '{in_ready: 1'b0, exec: 1'b1, out_valid: 1'b0, cond: UC_ALWAYS,
                      jump_to: UA_DRAIN, next_to: UA_DRAIN};
      UA_DRAIN: w = '{in_ready: 1'b0, exec: 1'b0, out_valid: 1'b1, cond: UC_OUT_LAST,
                      jump_to: UA_FETCH, next_to: UA_DRAIN};
      default:  w = '{in_ready: 1'b0, exec: 1'b0, out_valid: 1'b0, cond: UC_ALWAYS,
                      jump_to: UA_FETCH, next_to: UA_FETCH};
    endcase
    return w;
  endfunction

endpackage

@@ sv/tlr_useq.sv @@
// Microprogram sequencer: step counter, control ROM and conditional jumps.
module tlr_useq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  out_ready,
  input  logic                  out_last,
  output logic                  in_ready,
  output logic                  out_valid,
  output tlr_pkg::tlr_ctrl_t    ctrl
);

  logic [1:0]          upc;
  logic [1:0]          upc_next;
  tlr_pkg::tlr_uword_t uword;
  logic                cond_true;

  assign uword     = tlr_pkg::tlr_urom(upc);
  assign in_ready  = uword.in_ready;
  assign out_valid = uword.out_valid;

  assign ctrl.load_item = uword.in_ready & in_valid;
  assign ctrl.exec      = uword.exec;
  assign ctrl.out_take  = uword.out_valid & out_ready;

  always_comb begin
    case (uword.cond)
      tlr_pkg::UC_NEVER:    cond_true = 1'b0;
      tlr_pkg::UC_ALWAYS:   cond_true = 1'b1;
      tlr_pkg::UC_IN_ACC:   cond_true = uword.in_ready & in_valid;
      tlr_pkg::UC_OUT_LAST: cond_true = uword.out_valid & out_ready & out_last;
      default:              cond_true = 1'b0;
    endcase
    upc_next = cond_true ? uword.jump_to : uword.next_to;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= tlr_pkg::UA_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

@@ sv/tlr_datapath.sv @@
// Datapath: parser state, configuration, value store and result registers.
module tlr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tlr_pkg::tlr_ctrl_t                  ctrl,
  input  logic                                cfg_write,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlr_pkg::LABEL_W-1:0]         cfg_data,
  input  logic [1:0]                          opcode,
  input  logic [7:0]                          byte_value,
  input  logic                                counter_select,
  output logic [4:0]                          event_res,
  output logic [1:0]                          status,
  output logic                                activation,
  output logic                                selection,
  output logic [6:0]                          value_char,
  output logic [4:0]                          value_length,
  output logic                                last
);

  localparam int FW = tlr_pkg::FIELD_W;
  localparam int AW = tlr_pkg::FIELD_AW;

  logic [tlr_pkg::LABEL_W-1:0]   search_label;
  logic [tlr_pkg::LEN_W-1:0]     search_label_length;
  logic [tlr_pkg::TIMEOUT_W-1:0] timeout_ms;

  logic [1:0] item_op;
  logic [6:0] item_car;
  logic       item_sel;

  logic [2:0]  stage, stage_next;
  logic [1:0]  read_status, read_status_next;
  logic        sel, sel_next;
  logic        act, act_next;
  logic [15:0] elapsed, elapsed_next;
  logic [FW-1:0] field_index, field_index_next;
  logic        label_match, label_match_next;
  logic [5:0]  cksum, cksum_next;
  logic        cksum_err, cksum_err_next;
  logic [FW-1:0] stored_len, stored_len_next;

  logic [4:0]  ev;
  logic        mem_we;
  logic [6:0]  value_mem [tlr_pkg::MAX_FIELD];
  logic [AW-1:0] emit_idx;
  logic [AW-1:0] emit_idx_next;
  logic [15:0] elapsed_inc;
  logic [7:0]  want;
  logic [5:0]  cksum_add;
  logic        label_ok;

  assign elapsed_inc   = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;
  assign want          = search_label[8 * field_index[tlr_pkg::LABEL_AW-1:0] +: 8];
  assign cksum_add     = cksum + item_car[5:0];
  assign label_ok      = (field_index < FW'(tlr_pkg::LABEL_CHARS)) &&
                         (field_index < FW'(search_label_length));
  assign emit_idx_next = emit_idx + AW'(1);

  always_comb begin
    stage_next       = stage;
    read_status_next = read_status;
    sel_next         = sel;
    act_next         = act;
    elapsed_next     = elapsed;
    field_index_next = field_index;
    label_match_next = label_match;
    cksum_next       = cksum;
    cksum_err_next   = cksum_err;
    stored_len_next  = stored_len;
    ev               = tlr_pkg::EV_NOP;
    mem_we           = 1'b0;
    if (item_op == tlr_pkg::OP_START) begin
      stored_len_next  = '0;
      sel_next         = item_sel;
      read_status_next = tlr_pkg::RS_RUN;
      act_next         = 1'b1;
      elapsed_next     = '0;
      stage_next       = tlr_pkg::ST_FRAME;
    end else if (item_op == tlr_pkg::OP_ABORT) begin
      act_next         = 1'b0;
      sel_next         = 1'b0;
      read_status_next = tlr_pkg::RS_IDLE;
    end else if (read_status != tlr_pkg::RS_RUN) begin
      ev = tlr_pkg::EV_NOP;
    end else if (item_op == tlr_pkg::OP_TICK) begin
      elapsed_next = elapsed_inc;
      if (elapsed_inc > timeout_ms) begin
        read_status_next = tlr_pkg::RS_ERR;
        act_next         = 1'b0;
        ev               = tlr_pkg::EV_TIMEOUT;
      end
    end else if (item_car == tlr_pkg::CH_ETX || item_car == tlr_pkg::CH_EOT) begin
      stage_next     = tlr_pkg::ST_FRAME;
      cksum_err_next = 1'b0;
      ev             = tlr_pkg::EV_FRAME_END;
    end else begin
      unique case (stage)
        tlr_pkg::ST_FRAME: begin
          if (item_car == tlr_pkg::CH_STX) begin
            stage_next = tlr_pkg::ST_LINE;
            ev         = tlr_pkg::EV_FRAME_GO;
          end else begin
            ev = tlr_pkg::EV_WAIT_START;
          end
        end
        tlr_pkg::ST_LINE: begin
          if (item_car == tlr_pkg::CH_LF) begin
            field_index_next = '0;
            label_match_next = 1'b1;
            cksum_next       = '0;
            stage_next       = tlr_pkg::ST_LABEL;
            ev               = tlr_pkg::EV_LINE_GO;
          end else begin
            stage_next = tlr_pkg::ST_FRAME;
            ev         = tlr_pkg::EV_LINE_ERR0;
          end
        end
        tlr_pkg::ST_LABEL: begin
          if (field_index >= FW'(tlr_pkg::MAX_FIELD)) begin
            stage_next = tlr_pkg::ST_FRAME;
            ev         = tlr_pkg::EV_OVERFLOW;
          end else if (item_car == tlr_pkg::CH_SPACE) begin
            if (field_index != FW'(search_label_length)) begin
              label_match_next = 1'b0;
            end
            cksum_next       = cksum + 6'h20;
            field_index_next = '0;
            stage_next       = tlr_pkg::ST_VALUE;
            ev               = tlr_pkg::EV_LABEL_DONE;
          end else begin
            if (!label_ok || want != {1'b0, item_car}) begin
              label_match_next = 1'b0;
            end
            cksum_next       = cksum_add;
            field_index_next = field_index + FW'(1);
            ev               = tlr_pkg::EV_LABEL_CHAR;
          end
        end
        tlr_pkg::ST_VALUE: begin
          if (field_index >= FW'(tlr_pkg::MAX_FIELD)) begin
            stage_next = tlr_pkg::ST_FRAME;
            ev         = tlr_pkg::EV_OVERFLOW;
          end else if (item_car == tlr_pkg::CH_SPACE) begin
            stored_len_next = field_index;
            stage_next      = tlr_pkg::ST_CKSUM;
            ev              = tlr_pkg::EV_VALUE_DONE;
          end else begin
            mem_we           = 1'b1;
            cksum_next       = cksum_add;
            field_index_next = field_index + FW'(1);
            ev               = tlr_pkg::EV_VALUE_CHAR;
          end
        end
        tlr_pkg::ST_CKSUM: begin
          stage_next = tlr_pkg::ST_EOL;
          if (item_car == {1'b0, cksum} + 7'h20) begin
            cksum_err_next = 1'b0;
            ev             = tlr_pkg::EV_CKSUM_OK;
          end else begin
            cksum_err_next = 1'b1;
            ev             = tlr_pkg::EV_CKSUM_BAD;
          end
        end
        tlr_pkg::ST_EOL: begin
          if (item_car == tlr_pkg::CH_CR) begin
            if (!cksum_err && label_match) begin
              read_status_next = tlr_pkg::RS_DATA;
              act_next         = 1'b0;
              ev               = tlr_pkg::EV_FOUND;
            end else begin
              stage_next = tlr_pkg::ST_LINE;
              ev         = tlr_pkg::EV_NOT_FOUND;
            end
          end else begin
            stage_next = tlr_pkg::ST_FRAME;
            ev         = tlr_pkg::EV_LINE_ERR;
          end
        end
        default: begin
          stage_next = tlr_pkg::ST_FRAME;
          ev         = tlr_pkg::EV_NOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_label        <= '0;
      search_label_length <= '0;
      timeout_ms          <= tlr_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tlr_pkg::REG_LABEL:     search_label        <= cfg_data;
        tlr_pkg::REG_LABEL_LEN: search_label_length <= cfg_data[tlr_pkg::LEN_W-1:0];
        tlr_pkg::REG_TIMEOUT:   timeout_ms          <= cfg_data[tlr_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      item_op  <= opcode;
      item_car <= byte_value[6:0];
      item_sel <= counter_select;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= tlr_pkg::ST_FRAME;
      read_status <= tlr_pkg::RS_IDLE;
      sel         <= 1'b0;
      act         <= 1'b0;
      elapsed     <= '0;
      field_index <= '0;
      label_match <= 1'b1;
      cksum       <= '0;
      cksum_err   <= 1'b0;
      stored_len  <= '0;
    end else if (ctrl.exec) begin
      stage       <= stage_next;
      read_status <= read_status_next;
      sel         <= sel_next;
      act         <= act_next;
      elapsed     <= elapsed_next;
      field_index <= field_index_next;
      label_match <= label_match_next;
      cksum       <= cksum_next;
      cksum_err   <= cksum_err_next;
      stored_len  <= stored_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && mem_we) begin
      value_mem[field_index[AW-1:0]] <= item_car;
    end
  end

  // Result registers; the value store is read here, one entry per result.
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      event_res  <= ev;
      status     <= read_status_next;
      activation <= act_next;
      selection  <= sel_next;
      emit_idx   <= '0;
      if (ev == tlr_pkg::EV_FOUND) begin
        value_length <= 5'(stored_len);
        value_char   <= (stored_len != '0) ? value_mem[0] : '0;
        last         <= (stored_len <= FW'(1));
      end else begin
        value_length <= '0;
        value_char   <= '0;
        last         <= 1'b1;
      end
    end else if (ctrl.out_take && !last) begin
      emit_idx   <= emit_idx_next;
      value_char <= value_mem[emit_idx_next];
      last       <= ({1'b0, emit_idx_next} + FW'(1)) == stored_len;
    end
  end

endmodule

@@ sv/teleinfo_label_reader.sv @@
// Top level of the teleinformation label reader: sequencer and datapath.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    opcode, byte_value, counter_select
//   out      output     out_valid / out_ready  event_res, status, activation, selection,
//                                              value_char, value_length, last
//   cfg      input      cfg_write              cfg_index, cfg_data
//
// Each item runs a three-step microprogram: fetch, execute, drain.
// An item holds the sequencer until its last result is taken (a found line gives
// one per value character); the drain step holds one result at a time.
// A stalled output holds the sequencer in the drain step, with in_ready low.
// Synchronous reset returns the sequencer to fetch and the parser to frame wait.
module teleinfo_label_reader (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic [7:0]                      byte_value,
  input  logic                            counter_select,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [4:0]                      event_res,
  output logic [1:0]                      status,
  output logic                            activation,
  output logic                            selection,
  output logic [6:0]                      value_char,
  output logic [4:0]                      value_length,
  output logic                            last,
  input  logic                            cfg_write,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlr_pkg::LABEL_W-1:0]     cfg_data
);

  tlr_pkg::tlr_ctrl_t ctrl;

  tlr_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .out_last  (last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  tlr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .byte_value     (byte_value),
    .counter_select (counter_select),
    .event_res      (event_res),
    .status         (status),
    .activation     (activation),
    .selection      (selection),
    .value_char     (value_char),
    .value_length   (value_length),
    .last           (last)
  );

endmodule

@@ dv/testbench.sv @@
// Testbench for the teleinformation label reader, with a predictor for every result.
`timescale 1ns / 1ps

module testbench;

  localparam logic [6:0] CKSUM_BIAS = 7'h20;

  typedef logic [7:0] chars_t[$];

  typedef struct {
    logic [4:0] event_res;
    logic [1:0] status;
    logic       activation;
    logic       selection;
    logic [6:0] value_char;
    logic [4:0] value_length;
    logic       last;
  } reader_result_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [1:0]                    opcode;
  logic [7:0]                    byte_value;
  logic                          counter_select;
  logic                          out_valid;
  logic                          out_ready;
  logic [4:0]                    event_res;
  logic [1:0]                    status;
  logic                          activation;
  logic                          selection;
  logic [6:0]                    value_char;
  logic [4:0]                    value_length;
  logic                          last;
  logic                          cfg_write;
  logic [tlr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tlr_pkg::LABEL_W-1:0]   cfg_data;

  teleinfo_label_reader DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .byte_value(byte_value),
    .counter_select(counter_select),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_res(event_res),
    .status(status),
    .activation(activation),
    .selection(selection),
    .value_char(value_char),
    .value_length(value_length),
    .last(last),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predicted reader state and configuration.
  logic [tlr_pkg::LABEL_W-1:0]   lbl;
  logic [tlr_pkg::LEN_W-1:0]     lbl_len;
  logic [tlr_pkg::TIMEOUT_W-1:0] tmo;
  logic [2:0]                    stage;
  logic [1:0]                    rd_status;
  logic                          meter;
  logic                          act_lvl;
  logic [15:0]                   elapsed;
  int                            fidx;
  logic                          label_ok;
  logic [5:0]                    csum;
  logic                          csum_err;
  logic [6:0]                    val_store[tlr_pkg::MAX_FIELD];
  logic [4:0]                    store_len;

  reader_result_t reader_results_q[$];
  reader_result_t oldest;

  int  errors = 0;
  int  items_sent = 0;
  int  worked_items = 0;
  int  results_checked = 0;
  int  found_lines = 0;
  int  timeouts_seen = 0;
  int  hold_off = 0;
  bit  calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Run did not complete in time.");
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void expect_result(input logic [4:0] ev, input logic [6:0] ch,
                                        input logic [4:0] len, input logic lst);
    reader_result_t r;
    r.event_res    = ev;
    r.status       = rd_status;
    r.activation   = act_lvl;
    r.selection    = meter;
    r.value_char   = ch;
    r.value_length = len;
    r.last         = lst;
    reader_results_q.push_back(r);
  endfunction

  function automatic void reader_step(input logic [1:0] op, input logic [7:0] data,
                                      input logic meter_sel);
    logic [6:0] c;
    int n;
    c = data[6:0];
    if (op == tlr_pkg::OP_START) begin
      foreach (val_store[k]) val_store[k] = '0;
      store_len = '0;
      meter     = meter_sel;
      rd_status = tlr_pkg::RS_RUN;
      act_lvl   = 1'b1;
      elapsed   = '0;
      stage     = tlr_pkg::ST_FRAME;
      expect_result(tlr_pkg::EV_NOP, '0, '0, 1'b1);
    end else if (op == tlr_pkg::OP_ABORT) begin
      act_lvl   = 1'b0;
      meter     = 1'b0;
      rd_status = tlr_pkg::RS_IDLE;
      expect_result(tlr_pkg::EV_NOP, '0, '0, 1'b1);
    end else if (rd_status != tlr_pkg::RS_RUN) begin
      expect_result(tlr_pkg::EV_NOP, '0, '0, 1'b1);
    end else if (op == tlr_pkg::OP_TICK) begin
      if (elapsed != 16'hFFFF) elapsed++;
      if (elapsed > tmo) begin
        rd_status = tlr_pkg::RS_ERR;
        act_lvl   = 1'b0;
        timeouts_seen++;
        expect_result(tlr_pkg::EV_TIMEOUT, '0, '0, 1'b1);
      end else begin
        expect_result(tlr_pkg::EV_NOP, '0, '0, 1'b1);
      end
    end else if (c == tlr_pkg::CH_ETX || c == tlr_pkg::CH_EOT) begin
      stage    = tlr_pkg::ST_FRAME;
      csum_err = 1'b0;
      expect_result(tlr_pkg::EV_FRAME_END, '0, '0, 1'b1);
    end else begin
      case (stage)
        tlr_pkg::ST_FRAME: begin
          if (c == tlr_pkg::CH_STX) begin
            stage = tlr_pkg::ST_LINE;
            expect_result(tlr_pkg::EV_FRAME_GO, '0, '0, 1'b1);
          end else begin
            expect_result(tlr_pkg::EV_WAIT_START, '0, '0, 1'b1);
          end
        end
        tlr_pkg::ST_LINE: begin
          if (c == tlr_pkg::CH_LF) begin
            fidx     = 0;
            label_ok = 1'b1;
            csum     = '0;
            stage    = tlr_pkg::ST_LABEL;
            expect_result(tlr_pkg::EV_LINE_GO, '0, '0, 1'b1);
          end else begin
            stage = tlr_pkg::ST_FRAME;
            expect_result(tlr_pkg::EV_LINE_ERR0, '0, '0, 1'b1);
          end
        end
        tlr_pkg::ST_LABEL: begin
          if (fidx >= tlr_pkg::MAX_FIELD) begin
            stage = tlr_pkg::ST_FRAME;
            expect_result(tlr_pkg::EV_OVERFLOW, '0, '0, 1'b1);
          end else if (c == tlr_pkg::CH_SPACE) begin
            if (fidx != int'(lbl_len)) label_ok = 1'b0;
            csum  = csum + 6'(CKSUM_BIAS);
            fidx  = 0;
            stage = tlr_pkg::ST_VALUE;
            expect_result(tlr_pkg::EV_LABEL_DONE, '0, '0, 1'b1);
          end else begin
            if (fidx < tlr_pkg::LABEL_CHARS && fidx < int'(lbl_len)) begin
              if (lbl[8*fidx +: 8] != {1'b0, c}) label_ok = 1'b0;
            end else begin
              label_ok = 1'b0;
            end
            csum = csum + 6'(c);
            fidx++;
            expect_result(tlr_pkg::EV_LABEL_CHAR, '0, '0, 1'b1);
          end
        end
        tlr_pkg::ST_VALUE: begin
          if (fidx >= tlr_pkg::MAX_FIELD) begin
            stage = tlr_pkg::ST_FRAME;
            expect_result(tlr_pkg::EV_OVERFLOW, '0, '0, 1'b1);
          end else if (c == tlr_pkg::CH_SPACE) begin
            store_len = 5'(fidx);
            stage     = tlr_pkg::ST_CKSUM;
            expect_result(tlr_pkg::EV_VALUE_DONE, '0, '0, 1'b1);
          end else begin
            val_store[fidx] = c;
            csum = csum + 6'(c);
            fidx++;
            expect_result(tlr_pkg::EV_VALUE_CHAR, '0, '0, 1'b1);
          end
        end
        tlr_pkg::ST_CKSUM: begin
          stage = tlr_pkg::ST_EOL;
          if (c == {1'b0, csum} + CKSUM_BIAS) begin
            csum_err = 1'b0;
            expect_result(tlr_pkg::EV_CKSUM_OK, '0, '0, 1'b1);
          end else begin
            csum_err = 1'b1;
            expect_result(tlr_pkg::EV_CKSUM_BAD, '0, '0, 1'b1);
          end
        end
        tlr_pkg::ST_EOL: begin
          if (c == tlr_pkg::CH_CR) begin
            if (!csum_err && label_ok) begin
              rd_status = tlr_pkg::RS_DATA;
              act_lvl   = 1'b0;
              found_lines++;
              n = int'(store_len);
              if (n == 0) begin
                expect_result(tlr_pkg::EV_FOUND, '0, '0, 1'b1);
              end else begin
                for (int k = 0; k < n; k++) begin
                  expect_result(tlr_pkg::EV_FOUND, val_store[k], 5'(n), k == n - 1);
                end
              end
            end else begin
              stage = tlr_pkg::ST_LINE;
              expect_result(tlr_pkg::EV_NOT_FOUND, '0, '0, 1'b1);
            end
          end else begin
            stage = tlr_pkg::ST_FRAME;
            expect_result(tlr_pkg::EV_LINE_ERR, '0, '0, 1'b1);
          end
        end
        default: begin
          stage = tlr_pkg::ST_FRAME;
          expect_result(tlr_pkg::EV_NOP, '0, '0, 1'b1);
        end
      endcase
    end
  endfunction

  function automatic void check_field(input string name, input logic [6:0] want,
                                      input logic [6:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (reader_results_q.size() == 0) begin
        $error("Result with event_res %0d arrived with nothing pending", event_res);
        errors++;
      end else begin
        oldest = reader_results_q.pop_front();
        check_field("event_res", 7'(oldest.event_res), 7'(event_res));
        check_field("status", 7'(oldest.status), 7'(status));
        check_field("activation", 7'(oldest.activation), 7'(activation));
        check_field("selection", 7'(oldest.selection), 7'(selection));
        check_field("value_char", oldest.value_char, value_char);
        check_field("value_length", 7'(oldest.value_length), 7'(value_length));
        check_field("last", 7'(oldest.last), 7'(last));
        results_checked++;
      end
    end
  end

  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 15);
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] data,
                           input logic meter_sel);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    byte_value     <= data;
    counter_select <= meter_sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (op == tlr_pkg::OP_START || op == tlr_pkg::OP_ABORT || rd_status == tlr_pkg::RS_RUN) begin
      worked_items++;
    end
    reader_step(op, data, meter_sel);
  endtask

  task automatic send_byte(input logic [7:0] data);
    send_item(tlr_pkg::OP_BYTE, data, 1'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reader_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tlr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tlr_pkg::LABEL_W-1:0] data);
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      tlr_pkg::REG_LABEL:     lbl = data;
      tlr_pkg::REG_LABEL_LEN: lbl_len = data[tlr_pkg::LEN_W-1:0];
      tlr_pkg::REG_TIMEOUT:   tmo = data[tlr_pkg::TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  // Field characters never end a field or a frame; a zero character now and then.
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    c = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(8'h21, 8'h7E));
    c[7] = 1'($urandom);
    return c;
  endfunction

  function automatic chars_t random_chars(input int n);
    chars_t q;
    for (int i = 0; i < n; i++) q.push_back(field_char());
    return q;
  endfunction

  function automatic chars_t searched_label();
    chars_t q;
    logic [7:0] c;
    for (int i = 0; i < int'(lbl_len); i++) begin
      c = (i < tlr_pkg::LABEL_CHARS) ? lbl[8*i +: 8] : field_char();
      if (!c[7]) c[7] = 1'($urandom);
      q.push_back(c);
    end
    return q;
  endfunction

  task automatic send_line(input chars_t lab, input chars_t val, input bit bad_ck,
                           input bit bad_end);
    logic [5:0] acc;
    logic [6:0] ck;
    acc = 6'(CKSUM_BIAS);
    foreach (lab[i]) acc = acc + 6'(lab[i][6:0]);
    foreach (val[i]) acc = acc + 6'(val[i][6:0]);
    ck = {1'b0, acc} + CKSUM_BIAS;
    if (bad_ck) ck = ck ^ (7'd1 << $urandom_range(0, 5));
    send_byte({1'($urandom), tlr_pkg::CH_LF});
    foreach (lab[i]) send_byte(lab[i]);
    send_byte({1'($urandom), tlr_pkg::CH_SPACE});
    foreach (val[i]) send_byte(val[i]);
    send_byte({1'($urandom), tlr_pkg::CH_SPACE});
    send_byte({1'($urandom), ck});
    send_byte(bad_end ? field_char() : {1'($urandom), tlr_pkg::CH_CR});
  endtask

  task automatic random_config();
    logic [tlr_pkg::LABEL_W-1:0] word;
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      word = '1;
    end else if (r == 1) begin
      word = '0;
    end else begin
      for (int i = 0; i < 8; i++) begin
        c = field_char();
        word[8*i +: 8] = {1'b0, c[6:0]};
      end
    end
    write_reg(tlr_pkg::REG_LABEL, word);
    r = $urandom_range(0, 11);
    word = {$urandom, $urandom};
    word[tlr_pkg::LEN_W-1:0] = (r < 2) ? 4'd0 : (r < 4) ? 4'd8 :
                               (r < 5) ? 4'($urandom_range(9, 15)) :
                               4'($urandom_range(1, 7));
    write_reg(tlr_pkg::REG_LABEL_LEN, word);
    r = $urandom_range(0, 7);
    word = {$urandom, $urandom};
    word[tlr_pkg::TIMEOUT_W-1:0] = (r < 2) ? 16'($urandom_range(2, 12)) :
                                   (r < 3) ? 16'hFFFF : 16'($urandom_range(100, 60000));
    write_reg(tlr_pkg::REG_TIMEOUT, word);
  endtask

  task automatic random_frame();
    chars_t lab;
    chars_t val;
    int r;
    int vlen;
    calm = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 7) != 0) send_item(tlr_pkg::OP_START, 8'($urandom), 1'($urandom));
    if ($urandom_range(0, 4) == 0) send_item(tlr_pkg::OP_BYTE, 8'($urandom), 1'($urandom));
    send_byte({1'($urandom), tlr_pkg::CH_STX});
    repeat ($urandom_range(1, 3)) begin
      if (rd_status != tlr_pkg::RS_RUN) break;
      r = $urandom_range(0, 9);
      if (r < 5) begin
        lab = searched_label();
      end else if (r < 7) begin
        lab = searched_label();
        if (lab.size() == 0 || $urandom_range(0, 1) == 0) lab.push_back(field_char());
        else lab[$urandom_range(0, lab.size() - 1)] = field_char();
      end else if (r < 9) begin
        lab = random_chars($urandom_range(0, 9));
      end else begin
        lab = random_chars($urandom_range(15, 17));
      end
      r = $urandom_range(0, 9);
      vlen = (r < 7) ? $urandom_range(0, 4) : (r == 7) ? $urandom_range(5, 15) :
             (r == 8) ? tlr_pkg::MAX_FIELD : tlr_pkg::MAX_FIELD + 1;
      val = random_chars(vlen);
      send_line(lab, val, $urandom_range(0, 7) == 0, $urandom_range(0, 11) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(tlr_pkg::OP_TICK, 8'($urandom), 1'($urandom));
        end
      end
      if ($urandom_range(0, 9) == 0) send_item(2'($urandom), 8'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 2) == 0) begin
      send_byte({1'($urandom), ($urandom_range(0, 1) == 0) ? tlr_pkg::CH_ETX : tlr_pkg::CH_EOT});
    end
  endtask

  task automatic test_idle_items();
    send_item(tlr_pkg::OP_BYTE, 8'hFF, 1'b1);
    send_item(tlr_pkg::OP_TICK, 8'h00, 1'b0);
    send_item(tlr_pkg::OP_START, 8'h00, 1'b1);
    send_item(tlr_pkg::OP_ABORT, 8'hFF, 1'b1);
  endtask

  task automatic test_empty_value();
    chars_t lab;
    chars_t val;
    lab.push_back(8'hC5);
    wait_drained();
    write_reg(tlr_pkg::REG_LABEL, 64'h45);
    write_reg(tlr_pkg::REG_LABEL_LEN, 64'h1);
    send_item(tlr_pkg::OP_START, 8'h00, 1'b1);
    send_byte({1'b1, tlr_pkg::CH_STX});
    send_line(lab, val, 1'b0, 1'b0);
    send_item(tlr_pkg::OP_START, 8'h00, 1'b0);
    send_byte(8'h00);
    send_byte({1'b0, tlr_pkg::CH_STX});
    send_byte({1'b0, tlr_pkg::CH_ETX});
    send_byte({1'b1, tlr_pkg::CH_EOT});
    send_item(tlr_pkg::OP_ABORT, 8'h00, 1'b0);
  endtask

  task automatic test_timeout();
    wait_drained();
    write_reg(tlr_pkg::REG_TIMEOUT, 64'h1);
    send_item(tlr_pkg::OP_START, 8'h00, 1'b0);
    send_item(tlr_pkg::OP_TICK, 8'h00, 1'b0);
    send_item(tlr_pkg::OP_TICK, 8'h00, 1'b0);
    send_item(tlr_pkg::OP_TICK, 8'h00, 1'b0);
  endtask

  // With the maximum timeout a few ticks fire nothing; a lower limit written
  // while the read goes on fires on the next tick.
  task automatic test_max_timeout();
    wait_drained();
    write_reg(tlr_pkg::REG_TIMEOUT, 64'hFFFF);
    send_item(tlr_pkg::OP_START, 8'h00, 1'b1);
    repeat (5) send_item(tlr_pkg::OP_TICK, 8'h00, 1'b0);
    wait_drained();
    write_reg(tlr_pkg::REG_TIMEOUT, 64'h5);
    send_item(tlr_pkg::OP_TICK, 8'h00, 1'b0);
  endtask

  task automatic test_random_frames();
    int first;
    first = worked_items;
    while (worked_items - first < 140) begin
      wait_drained();
      random_config();
      repeat (2) random_frame();
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_drained();
    write_reg(tlr_pkg::REG_LABEL, 64'h5050_4150);
    write_reg(tlr_pkg::REG_LABEL_LEN, 64'h4);
    write_reg(tlr_pkg::REG_TIMEOUT, 64'hFFFF);
    calm = 1'b0;
    send_item(tlr_pkg::OP_START, 8'h00, 1'b1);
    send_byte({1'b0, tlr_pkg::CH_STX});
    hold_off = 300;
    send_line(searched_label(), random_chars(tlr_pkg::MAX_FIELD), 1'b0, 1'b0);
    hold_off = 100;
    wait_drained();
  endtask

  task automatic test_quiet_finish();
    wait_drained();
    calm = 1'b1;
    write_reg(tlr_pkg::REG_LABEL, 64'h3130_0045_5341_4245);
    write_reg(tlr_pkg::REG_LABEL_LEN, 64'h8);
    send_item(tlr_pkg::OP_START, 8'h00, 1'b1);
    send_byte({1'b0, tlr_pkg::CH_STX});
    send_line(random_chars(3), random_chars(2), 1'b0, 1'b0);
    send_line(searched_label(), random_chars(tlr_pkg::MAX_FIELD), 1'b0, 1'b0);
    send_item(tlr_pkg::OP_ABORT, 8'h00, 1'b1);
  endtask

  initial begin
    int w;
    rst            = 1'b1;
    in_valid       = 1'b0;
    opcode         = tlr_pkg::OP_BYTE;
    byte_value     = '0;
    counter_select = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = tlr_pkg::REG_LABEL;
    cfg_data       = '0;
    lbl       = '0;
    lbl_len   = '0;
    tmo       = tlr_pkg::TIMEOUT_RESET;
    stage     = tlr_pkg::ST_FRAME;
    rd_status = tlr_pkg::RS_IDLE;
    meter     = 1'b0;
    act_lvl   = 1'b0;
    elapsed   = '0;
    fidx      = 0;
    label_ok  = 1'b1;
    csum      = '0;
    csum_err  = 1'b0;
    store_len = '0;
    foreach (val_store[k]) val_store[k] = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_idle_items();
    test_empty_value();
    test_timeout();
    test_max_timeout();
    test_random_frames();
    test_backpressure();
    test_quiet_finish();

    @(negedge clk);
    in_valid <= 1'b0;
    for (w = 0; w < 5000 && reader_results_q.size() != 0; w++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (reader_results_q.size() != 0) begin
      $error("%0d expected results never arrived", reader_results_q.size());
      errors++;
    end

    $display("Sent %0d items (%0d acted on while running or as commands), checked %0d results.",
             items_sent, worked_items, results_checked);
    $display("Lines found: %0d, read timeouts: %0d, errors: %0d.",
             found_lines, timeouts_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
